// ===== hdl/dsal_pkg.sv =====
// ----------------------------------------------------------------------------
// dsal_pkg
// Shared types and codes for the security access lockout unit.
// ----------------------------------------------------------------------------
package dsal_pkg;

   // response status codes
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_LENGTH   = 3'd1;
   localparam logic [2:0] ST_DELAY    = 3'd2;
   localparam logic [2:0] ST_COND     = 3'd3;
   localparam logic [2:0] ST_SEQ      = 3'd4;
   localparam logic [2:0] ST_EXCEEDED = 3'd5;
   localparam logic [2:0] ST_BADKEY   = 3'd6;
   localparam logic [2:0] ST_HANDLER  = 3'd7;

   // key verifier verdicts
   localparam logic [1:0] KEY_ACCEPTED = 2'd0;
   localparam logic [1:0] KEY_REJ_CODE = 2'd2;

   // csr register indexes
   localparam logic [2:0] CSR_SEED_SOURCE = 3'd0;
   localparam logic [2:0] CSR_KEY_CHECKER = 3'd1;
   localparam logic [2:0] CSR_ATT_LIMIT   = 3'd2;
   localparam logic [2:0] CSR_LOCKOUT_MS  = 3'd3;
   localparam logic [2:0] CSR_PERSIST     = 3'd4;

   localparam logic [6:0]  SUB_MASK         = 7'h7F;
   localparam logic [7:0]  DEFAULT_ATTEMPTS = 8'd3;
   localparam logic [31:0] DEFAULT_LOCKOUT  = 32'd10000;
   localparam logic [7:0]  ATTEMPTS_MAX     = 8'd255;
   localparam logic [11:0] MIN_REQ_LENGTH   = 12'd2;
   localparam logic [11:0] RSP_HDR_LENGTH   = 12'd2;

   typedef struct packed {
      logic        seed_source_present;
      logic        key_checker_present;
      logic [7:0]  attempt_limit;
      logic [31:0] lockout_ms;
      logic        persist_enable;
   } cfg_type;

   typedef struct packed {
      logic [11:0] request_length;
      logic [7:0]  subfunction_byte;
      logic [31:0] now_ms;
      logic        seed_failed;
      logic [7:0]  seed_error_code;
      logic [11:0] seed_length;
      logic [1:0]  key_verdict;
      logic [7:0]  key_error_code;
      logic [7:0]  active_session;
   } item_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  handler_code;
      logic [11:0] response_length;
      logic [7:0]  echo_subfunction;
      logic [6:0]  unlocked_level;
      logic        save_request;
      logic [7:0]  saved_session;
   } result_type;

   typedef struct packed {
      logic [31:0] lockout_deadline;
      logic [7:0]  failed_attempts;
      logic [6:0]  armed_level;
      logic [6:0]  current_level;
   } state_type;

endpackage

// ===== hdl/diag_security_access_lockout_unit.sv =====
// An accepted item is held in the input register, and its decided result in the result register.
// Throughput: one item per cycle while the response is not stalled; the decision logic sits between the two registers.
// The input register keeps taking items while a result waits, until both are full.
// Reset (synchronous, active high) clears lockout, attempts, armed and unlocked levels,
// empties both registers and restores the register defaults 1, 1, 0, 0, 0.
// ----------------------------------------------------------------------------
// diag_security_access_lockout_unit
// Security access controller: seed/key sequencing with attempt lockout.
// ----------------------------------------------------------------------------
module diag_security_access_lockout_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [11:0] req_request_length,
   input  logic [7:0]  req_subfunction_byte,
   input  logic [31:0] req_now_ms,
   input  logic        req_seed_failed,
   input  logic [7:0]  req_seed_error_code,
   input  logic [11:0] req_seed_length,
   input  logic [1:0]  req_key_verdict,
   input  logic [7:0]  req_key_error_code,
   input  logic [7:0]  req_active_session,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [7:0]  rsp_handler_code,
   output logic [11:0] rsp_response_length,
   output logic [7:0]  rsp_echo_subfunction,
   output logic [6:0]  rsp_unlocked_level,
   output logic        rsp_save_request,
   output logic [7:0]  rsp_saved_session,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import dsal_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   state_type  state_ff, state_nxt;
   item_type   item_ff, item_in;
   result_type result_ff, result_nxt;
   logic       in_valid_ff, in_valid_in;
   logic       out_valid_ff, out_valid_in;
   logic       advance;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      item_in.request_length   = req_request_length;
      item_in.subfunction_byte = req_subfunction_byte;
      item_in.now_ms           = req_now_ms;
      item_in.seed_failed      = req_seed_failed;
      item_in.seed_error_code  = req_seed_error_code;
      item_in.seed_length      = req_seed_length;
      item_in.key_verdict      = req_key_verdict;
      item_in.key_error_code   = req_key_error_code;
      item_in.active_session   = req_active_session;
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_SEED_SOURCE: cfg_in.seed_source_present = csr_wdata[0];
            CSR_KEY_CHECKER: cfg_in.key_checker_present = csr_wdata[0];
            CSR_ATT_LIMIT:   cfg_in.attempt_limit       = csr_wdata[7:0];
            CSR_LOCKOUT_MS:  cfg_in.lockout_ms          = csr_wdata;
            CSR_PERSIST:     cfg_in.persist_enable      = csr_wdata[0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   dsal_eval u_eval (
      .cfg       (cfg_ff),
      .state_cur (state_ff),
      .item      (item_ff),
      .state_nxt (state_nxt),
      .result    (result_nxt)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
         cfg_ff.seed_source_present <= 1'b1;
         cfg_ff.key_checker_present <= 1'b1;
         cfg_ff.attempt_limit       <= 8'd0;
         cfg_ff.lockout_ms          <= 32'd0;
         cfg_ff.persist_enable      <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         cfg_ff       <= cfg_in;
         if (advance) begin
            state_ff <= state_nxt;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= item_in;
      end
      if (advance) begin
         result_ff <= result_nxt;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_status           = result_ff.status;
   assign rsp_handler_code     = result_ff.handler_code;
   assign rsp_response_length  = result_ff.response_length;
   assign rsp_echo_subfunction = result_ff.echo_subfunction;
   assign rsp_unlocked_level   = result_ff.unlocked_level;
   assign rsp_save_request     = result_ff.save_request;
   assign rsp_saved_session    = result_ff.saved_session;

endmodule

// ===== hdl/dsal_eval.sv =====
// ----------------------------------------------------------------------------
// dsal_eval
// Decision logic for one security access request: length and lockout
// checks, seed arming, key sequencing and attempt counting.
// ----------------------------------------------------------------------------
module dsal_eval (
   input  dsal_pkg::cfg_type    cfg,
   input  dsal_pkg::state_type  state_cur,
   input  dsal_pkg::item_type   item,
   output dsal_pkg::state_type  state_nxt,
   output dsal_pkg::result_type result
);
   import dsal_pkg::*;

   logic [6:0]  sub;
   logic [6:0]  arm_level;
   logic [6:0]  key_level;
   logic [7:0]  limit;
   logic [31:0] lock_len;
   logic [7:0]  attempts_inc;
   logic        locked_out;
   logic [2:0]  status;
   logic [7:0]  code;
   logic [11:0] resp_len;
   logic        save;

   assign sub          = item.subfunction_byte[6:0] & SUB_MASK;
   assign arm_level    = {1'b0, sub[6:1]} + 7'd1;
   assign key_level    = {1'b0, sub[6:1]};
   assign limit        = (cfg.attempt_limit != 8'd0) ? cfg.attempt_limit : DEFAULT_ATTEMPTS;
   assign lock_len     = (cfg.lockout_ms != 32'd0) ? cfg.lockout_ms : DEFAULT_LOCKOUT;
   assign attempts_inc = (state_cur.failed_attempts < ATTEMPTS_MAX) ?
                         state_cur.failed_attempts + 8'd1 : state_cur.failed_attempts;
   assign locked_out   = (state_cur.lockout_deadline != 32'd0) &&
                         (item.now_ms < state_cur.lockout_deadline);

   always_comb begin
      state_nxt = state_cur;
      status    = ST_OK;
      code      = 8'd0;
      resp_len  = 12'd0;
      save      = 1'b0;
      if (item.request_length < MIN_REQ_LENGTH) begin
         status = ST_LENGTH;
      end else if (locked_out) begin
         status = ST_DELAY;
      end else begin
         state_nxt.lockout_deadline = 32'd0;
         if (sub[0]) begin
            // seed request
            if (!cfg.seed_source_present) begin
               status = ST_COND;
            end else if (item.seed_failed) begin
               status = ST_HANDLER;
               code   = item.seed_error_code;
            end else begin
               state_nxt.armed_level = arm_level;
               resp_len              = item.seed_length + RSP_HDR_LENGTH;
            end
         end else begin
            // key send, must match the armed level
            if (!cfg.key_checker_present) begin
               status = ST_COND;
            end else if (state_cur.armed_level == 7'd0 ||
                         state_cur.armed_level != key_level) begin
               status = ST_SEQ;
            end else if (item.key_verdict == KEY_ACCEPTED) begin
               state_nxt.failed_attempts = 8'd0;
               state_nxt.armed_level     = 7'd0;
               state_nxt.current_level   = key_level;
               save                      = cfg.persist_enable;
               resp_len                  = RSP_HDR_LENGTH;
            end else begin
               state_nxt.failed_attempts = attempts_inc;
               if (attempts_inc >= limit) begin
                  state_nxt.lockout_deadline = item.now_ms + lock_len;
                  status                     = ST_EXCEEDED;
               end else if (item.key_verdict == KEY_REJ_CODE) begin
                  status = ST_HANDLER;
                  code   = item.key_error_code;
               end else begin
                  status = ST_BADKEY;
               end
            end
         end
      end
   end

   always_comb begin
      result.status           = status;
      result.handler_code     = code;
      result.response_length  = resp_len;
      result.echo_subfunction = (status == ST_OK) ? item.subfunction_byte : 8'd0;
      result.unlocked_level   = state_nxt.current_level;
      result.save_request     = save;
      result.saved_session    = save ? item.active_session : 8'd0;
   end

endmodule

// ===== hdl/dsal_checker.sv =====
// ----------------------------------------------------------------------------
// dsal_checker
// Port-level checks for the security access lockout unit.
// ----------------------------------------------------------------------------
module dsal_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_status,
   input logic [7:0]  rsp_handler_code,
   input logic [11:0] rsp_response_length,
   input logic [7:0]  rsp_echo_subfunction,
   input logic [6:0]  rsp_unlocked_level,
   input logic        rsp_save_request,
   input logic [7:0]  rsp_saved_session
);
   import dsal_pkg::*;

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_unlocked_level) && $stable(rsp_response_length))
      else $error("stalled result changed");

   // negative responses carry no length or echo
   a_neg_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |->
      rsp_response_length == 12'd0 && rsp_echo_subfunction == 8'd0)
      else $error("negative response with payload");

   // handler code only with handler status
   a_code_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_HANDLER |-> rsp_handler_code == 8'd0)
      else $error("handler code without handler status");

   // a save only follows a successful key
   a_save_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_save_request |->
      rsp_status == ST_OK && rsp_response_length == 12'd2 && rsp_unlocked_level != 7'd0)
      else $error("save request without unlock");

   a_no_save_session: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_save_request |-> rsp_saved_session == 8'd0)
      else $error("session given without save");

endmodule

bind diag_security_access_lockout_unit dsal_checker u_dsal_checker (
   .clock                (clock),
   .reset                (reset),
   .rsp_valid            (rsp_valid),
   .rsp_ready            (rsp_ready),
   .rsp_status           (rsp_status),
   .rsp_handler_code     (rsp_handler_code),
   .rsp_response_length  (rsp_response_length),
   .rsp_echo_subfunction (rsp_echo_subfunction),
   .rsp_unlocked_level   (rsp_unlocked_level),
   .rsp_save_request     (rsp_save_request),
   .rsp_saved_session    (rsp_saved_session)
);
